[rtl/core/lhm_pkg.sv]
package lhm_pkg;

	localparam int NUM_BINS_DEF = 1024;
	localparam int NS_PER_US    = 1000;

	// period register holds the configured microseconds * 1000 (fits 30 bits for 20 bits in)
	localparam int          PERIOD_W     = 30;
	localparam int          INTERVAL_RST = 1000;
	localparam logic [29:0] PERIOD_RST   = 30'(INTERVAL_RST * NS_PER_US);

	// divide by 1000 via reciprocal: binned latencies stay below 65536 * 1000 < 2**26
	localparam int          DIV_W     = 26;
	localparam int          DIV_SHIFT = 36;
	localparam int          RECIP_W   = 27;
	localparam int          PROD_W    = DIV_W + RECIP_W;
	localparam logic [26:0] DIV_RECIP = 27'((64'd1 << DIV_SHIFT) / NS_PER_US);

	// bin addresses travel at the widest supported width (65536 bins)
	localparam int ADDR_MAX_W = 16;

	localparam int Q_DEPTH = 8;
	localparam int Q_PTR_W = 3;
	localparam int Q_CNT_W = 4;

	localparam logic [31:0] MAX32 = '1;
	localparam logic [47:0] MAX48 = '1;
	localparam logic [30:0] MAX31 = '1;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	typedef struct packed {
		logic               func;
		logic signed [31:0] wake_lat;
		logic [9:0]         bin_index;
	} lhm_in_t;

	typedef struct packed {
		logic [31:0] sample_count;
		logic [47:0] latency_sum;
		logic [30:0] min_latency;
		logic [30:0] max_latency;
		logic [31:0] overrun_count;
		logic [31:0] bin_value;
	} lhm_out_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic                  func;
		logic                  pos;
		logic                  overrun;
		logic                  rd_ok;
		logic [30:0]           lat;
		logic [ADDR_MAX_W-1:0] addr;
	} lhm_item_t;

endpackage

[rtl/core/lhm_ram.sv]
module lhm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/lhm_fifo.sv]
module lhm_fifo import lhm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lhm_item_t          push_item,
	input  logic               pop,
	output lhm_item_t          head,
	output logic               not_empty,
	output logic [Q_CNT_W-1:0] count
);

	lhm_item_t          buf_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

	assign head      = buf_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

endmodule

[rtl/core/lhm_front.sv]
module lhm_front import lhm_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	input  logic        in_fire,
	input  lhm_in_t     in_data,
	output logic        push,
	output lhm_item_t   push_item,
	output logic [1:0]  busy_cnt
);

	localparam int             AW        = $clog2(NUM_BINS);
	localparam logic [31:0]    BIN_LIMIT = 32'(NUM_BINS * NS_PER_US);
	localparam logic [AW-1:0]  LAST_BIN  = AW'(NUM_BINS - 1);

	logic [PERIOD_W-1:0] period_q;

	logic    v_s1;
	lhm_in_t in_s1;

	logic              v_s2;
	logic              func_s2;
	logic              pos_s2;
	logic              ovr_s2;
	logic              rdok_s2;
	logic              big_s2;
	logic [30:0]       lat_s2;
	logic [9:0]        idx_s2;
	logic [PROD_W-1:0] prod_s2;

	logic              pos_c;
	logic              ovr_c;
	logic              big_c;
	logic [15:0]       q0_c;
	logic [DIV_W-1:0]  rem_c;
	logic [15:0]       quo_c;
	logic [AW-1:0]     bin_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= PERIOD_W'(cfg_wdata) * PERIOD_W'(NS_PER_US);
			end
			v_s1 <= in_fire;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_s1 <= in_data;
		end
	end

	always_comb begin
		pos_c = !in_s1.wake_lat[31] && (in_s1.wake_lat[30:0] != '0);
		ovr_c = (in_s1.func == FUNC_RECORD) &&
			(in_s1.wake_lat > $signed({2'b00, period_q}));
		big_c = ({1'b0, in_s1.wake_lat[30:0]} >= BIN_LIMIT);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			func_s2 <= in_s1.func;
			pos_s2  <= pos_c;
			ovr_s2  <= ovr_c;
			rdok_s2 <= (32'(in_s1.bin_index) < 32'(NUM_BINS));
			big_s2  <= big_c;
			lat_s2  <= in_s1.wake_lat[30:0];
			idx_s2  <= in_s1.bin_index;
			prod_s2 <= PROD_W'(in_s1.wake_lat[DIV_W-1:0]) * PROD_W'(DIV_RECIP);
		end
	end

	// reciprocal estimate is exact or one low; one compare fixes it
	always_comb begin
		q0_c  = prod_s2[DIV_SHIFT +: 16];
		rem_c = lat_s2[DIV_W-1:0] - DIV_W'(DIV_W'(q0_c) * DIV_W'(NS_PER_US));
		quo_c = (rem_c >= DIV_W'(NS_PER_US)) ? q0_c + 16'd1 : q0_c;
		bin_c = big_s2 ? LAST_BIN : quo_c[AW-1:0];
	end

	always_comb begin
		push_item.func    = func_s2;
		push_item.pos     = pos_s2;
		push_item.overrun = ovr_s2;
		push_item.rd_ok   = rdok_s2;
		push_item.lat     = lat_s2;
		push_item.addr    = (func_s2 == FUNC_READ) ? ADDR_MAX_W'(idx_s2) : ADDR_MAX_W'(bin_c);
	end

	assign push     = v_s2;
	assign busy_cnt = {1'b0, v_s1} + {1'b0, v_s2};

endmodule

[rtl/core/lhm_back.sv]
module lhm_back import lhm_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  lhm_item_t q_head,
	output logic      q_pop,
	output logic      clearing,
	output logic      out_valid,
	input  logic      out_stall,
	output lhm_out_t  out_data
);

	localparam int            AW       = $clog2(NUM_BINS);
	localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic      v_s3;
	lhm_item_t item_s3;
	logic      adv_s3;

	logic          fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [31:0]   fwd_data_q;

	logic [31:0] count_q;
	logic [47:0] sum_q;
	logic [30:0] min_q;
	logic [30:0] max_q;
	logic [31:0] ovr_q;

	logic        out_v_q;
	lhm_out_t    out_data_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	logic          rec_c;
	logic [AW-1:0] addr_s3;
	logic [31:0]   cur_bin_c;
	logic [31:0]   inc_bin_c;
	logic [48:0]   sum_add_c;
	lhm_out_t      nxt_c;

	assign adv_s3  = v_s3 && (!out_v_q || !out_stall);
	assign q_pop   = q_valid && (!v_s3 || adv_s3);
	assign addr_s3 = item_s3.addr[AW-1:0];
	assign rec_c   = (item_s3.func == FUNC_RECORD) && item_s3.pos;

	// bin value: take the last write if it hit this address (read saw stale data)
	always_comb begin
		cur_bin_c = (fwd_v_q && (fwd_addr_q == addr_s3)) ? fwd_data_q : ram_rdata;
		inc_bin_c = (cur_bin_c == MAX32) ? cur_bin_c : cur_bin_c + 32'd1;
		sum_add_c = {1'b0, sum_q} + 49'(item_s3.lat);
	end

	always_comb begin
		nxt_c.sample_count  = count_q;
		nxt_c.latency_sum   = sum_q;
		nxt_c.min_latency   = min_q;
		nxt_c.max_latency   = max_q;
		nxt_c.overrun_count = ovr_q;
		nxt_c.bin_value     = '0;
		if (item_s3.overrun && (ovr_q != MAX32)) begin
			nxt_c.overrun_count = ovr_q + 32'd1;
		end
		if (rec_c) begin
			if (count_q != MAX32) begin
				nxt_c.sample_count = count_q + 32'd1;
			end
			nxt_c.latency_sum = sum_add_c[48] ? MAX48 : sum_add_c[47:0];
			if (item_s3.lat < min_q) begin
				nxt_c.min_latency = item_s3.lat;
			end
			if (item_s3.lat > max_q) begin
				nxt_c.max_latency = item_s3.lat;
			end
		end
		if ((item_s3.func == FUNC_READ) && item_s3.rd_ok) begin
			nxt_c.bin_value = cur_bin_c;
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = adv_s3 && rec_c;
			ram_waddr = addr_s3;
			ram_wdata = inc_bin_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			v_s3       <= 1'b0;
			fwd_v_q    <= 1'b0;
			count_q    <= '0;
			sum_q      <= '0;
			min_q      <= MAX31;
			max_q      <= '0;
			ovr_q      <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == LAST_BIN) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (q_pop) begin
				v_s3 <= 1'b1;
			end else if (adv_s3) begin
				v_s3 <= 1'b0;
			end
			if (adv_s3) begin
				if (rec_c) begin
					fwd_v_q <= 1'b1;
				end
				count_q <= nxt_c.sample_count;
				sum_q   <= nxt_c.latency_sum;
				min_q   <= nxt_c.min_latency;
				max_q   <= nxt_c.max_latency;
				ovr_q   <= nxt_c.overrun_count;
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s3 <= q_head;
		end
		if (adv_s3) begin
			out_data_q <= nxt_c;
			if (rec_c) begin
				fwd_addr_q <= addr_s3;
				fwd_data_q <= inc_bin_c;
			end
		end
	end

	lhm_ram #(
		.WIDTH(32),
		.DEPTH(NUM_BINS)
	) u_hist_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (q_pop),
		.raddr(q_head.addr[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign clearing  = clr_busy_q;
	assign out_valid = out_v_q;
	assign out_data  = out_data_q;

endmodule

[rtl/core/latency_histogram_monitor_core.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   lhm_in_t  (func, wake_lat, bin_index)
// out       output     out_valid / out_stall lhm_out_t (statistics, bin_value)
// cfg       input      cfg_we                cfg_wdata (period in us)
//
// One transaction per cycle sustained while out_stall is low; one result per input.
// out_valid rises after the accepting edge through s2, the queue slot, the RAM read stage
// and the output register. Rate is set by the histogram read-modify-write, forwarded from
// the last write. After reset a clearing pass zeroes the histogram RAM, with in_stall high.
// in_stall also rises when the queue and the front stages together hold eight transactions;
// out_stall holds the output register and, behind it, the back stage.
module latency_histogram_monitor_core import lhm_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  lhm_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output lhm_out_t    out_data
);

	logic               in_fire;
	logic               push;
	lhm_item_t          push_item;
	logic [1:0]         busy_cnt;
	logic               pop;
	lhm_item_t          head;
	logic               not_empty;
	logic [Q_CNT_W-1:0] q_count;
	logic               clearing;

	// every transaction in the front already owns a queue slot
	assign in_stall = clearing ||
		((5'(q_count) + 5'(busy_cnt)) >= 5'(Q_DEPTH));
	assign in_fire  = in_valid && !in_stall;

	lhm_front #(
		.NUM_BINS(NUM_BINS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_fire  (in_fire),
		.in_data  (in_data),
		.push     (push),
		.push_item(push_item),
		.busy_cnt (busy_cnt)
	);

	lhm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.count    (q_count)
	);

	lhm_back #(
		.NUM_BINS(NUM_BINS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_head   (head),
		.q_pop    (pop),
		.clearing (clearing),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
